### rtl/brd_pkg.sv
package brd_pkg;

    // Ring geometry; the depth must be a power of two so slot indexes wrap
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 3'd0,
        CMD_DUMP       = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_PUSH_FRONT = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_POP_FRONT  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [63:0]        name_low;
        logic [63:0]        name_mid;
        logic [31:0]        name_high;
        logic signed [31:0] age;
    } record_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                has_record;
        record_t             rec;
        logic [CNT_W-1:0]    occupancy;
        logic                last;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_record;
        logic advance;
    } ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic needs_read;
        logic more;
    } dp_status_t;

endpackage

### rtl/brd_if.sv
interface brd_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [31:0]        name_high;
    logic signed [31:0] age;

    modport source (output valid, command, name_low, name_mid, name_high, age,
                    input ready);
    modport sink   (input valid, command, name_low, name_mid, name_high, age,
                    output ready);
endinterface

interface brd_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               has_record;
    logic [63:0]        out_name_low;
    logic [63:0]        out_name_mid;
    logic [31:0]        out_name_high;
    logic signed [31:0] out_age;
    logic [4:0]         occupancy;
    logic               last;

    modport source (output valid, status, has_record, out_name_low, out_name_mid,
                    out_name_high, out_age, occupancy, last,
                    input ready);
    modport sink   (input valid, status, has_record, out_name_low, out_name_mid,
                    out_name_high, out_age, occupancy, last,
                    output ready);
endinterface

### rtl/brd_ctrl.sv
module brd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  brd_pkg::dp_status_t st,
    output brd_pkg::ctl_t       ctl
);
    import brd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.execute = 1'b1;
                state_next  = st.needs_read ? S_READ : S_OUT;
            end
            S_READ:
            begin
                ctl.load_record = 1'b1;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (st.more)
                    begin
                        // next dump entry: read is issued this cycle
                        ctl.advance = 1'b1;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/brd_datapath.sv
module brd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  brd_pkg::ctl_t                 ctl,
    output brd_pkg::dp_status_t           st,
    input  logic [brd_pkg::CMD_W-1:0]     command,
    input  brd_pkg::record_t              rec_in,
    output brd_pkg::result_t              res
);
    import brd_pkg::*;

    record_t          mem [DEPTH];
    record_t          rd_data_reg;
    record_t          rec_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [IDX_W-1:0] front_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] walk_reg;
    result_t          res_reg;

    logic             full;
    logic             empty;
    logic             is_push;
    logic             is_pop;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] rd_off;
    logic [CNT_W-1:0] walk_inc;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign is_push  = (cmd_reg == CMD_PUSH_BACK) || (cmd_reg == CMD_PUSH_FRONT);
    assign is_pop   = (cmd_reg == CMD_POP_BACK) || (cmd_reg == CMD_POP_FRONT);
    assign walk_inc = walk_reg + 1'b1;

    assign st.needs_read = !empty && (is_pop || (cmd_reg == CMD_DUMP));
    assign st.more       = !res_reg.last;
    assign res           = res_reg;

    // Write slot: behind the back, or ahead of the front
    assign wr_en   = ctl.execute && is_push && !full;
    assign wr_addr = (cmd_reg == CMD_PUSH_BACK) ? front_reg + count_reg[IDX_W-1:0]
                                                : front_reg - 1'b1;

    // Read slot offset from the front: back entry on pop back, front entry on other executes, else next walk position
    always_comb
    begin
        rd_off = walk_inc;
        if (ctl.execute)
        begin
            rd_off = (cmd_reg == CMD_POP_BACK) ? count_reg - 1'b1 : '0;
        end
    end
    assign rd_addr = front_reg + rd_off[IDX_W-1:0];

    // Record store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= rec_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Captured command and payload
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= command;
            rec_reg <= rec_in;
        end
    end

    // Ring pointers and dump walk position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            walk_reg  <= '0;
        end
        else if (ctl.execute)
        begin
            walk_reg <= '0;
            case (cmd_reg)
                CMD_CLEAR:
                begin
                    front_reg <= '0;
                    count_reg <= '0;
                end
                CMD_PUSH_BACK:
                begin
                    if (!full)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                CMD_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        front_reg <= front_reg - 1'b1;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (!empty)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        front_reg <= front_reg + 1'b1;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (ctl.advance)
        begin
            walk_reg <= walk_inc;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctl.execute)
        begin
            // results without a record; record-bearing ones load after the read
            res_reg.has_record <= 1'b0;
            res_reg.rec        <= '0;
            res_reg.last       <= 1'b1;
            res_reg.status     <= ST_OK;
            res_reg.occupancy  <= count_reg;
            case (cmd_reg)
                CMD_CLEAR:
                begin
                    res_reg.occupancy <= '0;
                end
                CMD_PUSH_BACK, CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        res_reg.status <= ST_FULL;
                    end
                    else
                    begin
                        res_reg.occupancy <= count_reg + 1'b1;
                    end
                end
                CMD_DUMP, CMD_POP_BACK, CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        res_reg.status <= ST_EMPTY;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (ctl.load_record)
        begin
            res_reg.status     <= ST_OK;
            res_reg.has_record <= 1'b1;
            res_reg.rec        <= rd_data_reg;
            res_reg.occupancy  <= count_reg;
            res_reg.last       <= is_pop || (walk_inc == count_reg);
        end
    end

endmodule

### rtl/bounded_record_deque.sv
// Channel  Dir  Transfer when          Payload
// cmd      in   cmd.valid & cmd.ready  command, name_low/mid/high, age
// rsp      out  rsp.valid & rsp.ready  status, has_record, out_name_*, out_age,
//                                      occupancy, last
//
// One command at a time; cmd.ready is high only while idle, so a new command is taken
// only after the response to the last one has transferred. Clear, push and unused
// codes register their result in the execute step; pop and dump on a non-empty ring
// add a read step (the store read is registered); so does each further dump record.
// Reset clears the ring pointers and the controller; the store needs no clearing.
// A stalled rsp holds the block until its transfer.
module bounded_record_deque (
    input logic      clk,
    input logic      rst_n,
    brd_cmd_if.sink  cmd,
    brd_rsp_if.source rsp
);
    import brd_pkg::*;

    ctl_t       ctl;
    dp_status_t st;
    record_t    rec_in;
    result_t    res;

    assign rec_in.name_low  = cmd.name_low;
    assign rec_in.name_mid  = cmd.name_mid;
    assign rec_in.name_high = cmd.name_high;
    assign rec_in.age       = cmd.age;

    // Sequencer
    brd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .st        (st),
        .ctl       (ctl)
    );

    // Record store, ring pointers and result register
    brd_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .st      (st),
        .command (cmd.command),
        .rec_in  (rec_in),
        .res     (res)
    );

    assign rsp.status        = res.status;
    assign rsp.has_record    = res.has_record;
    assign rsp.out_name_low  = res.rec.name_low;
    assign rsp.out_name_mid  = res.rec.name_mid;
    assign rsp.out_name_high = res.rec.name_high;
    assign rsp.out_age       = res.rec.age;
    assign rsp.occupancy     = res.occupancy;
    assign rsp.last          = res.last;

endmodule
